### hdl/graph_edge_buffer_table_assert.svh
// Assertion macros shared by the checker of the edge table.
`ifndef GRAPH_EDGE_BUFFER_TABLE_ASSERT_SVH
`define GRAPH_EDGE_BUFFER_TABLE_ASSERT_SVH

// An implication that must hold at every clock edge outside reset.
`define GEBT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that must hold in the cycle after another.
`define GEBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/gebt_pkg.sv
package gebt_pkg;

	localparam int EdgeCapacityDefault = 64;
	localparam int DataW = 32;
	localparam int LabelW = 8;
	localparam int DegW = 7;
	localparam int InTdataW = 144;
	localparam int OutTdataW = 144;
	// Internal result word: the tdata fields with the last flag on top.
	localparam int ResW = 139;

	typedef enum logic [3:0] {
		CMD_ADD      = 4'd0,
		CMD_DEL_EDGE = 4'd1,
		CMD_DEL_VTX  = 4'd2,
		CMD_LIST_IN  = 4'd3,
		CMD_LIST_OUT = 4'd4,
		CMD_LIST_ALL = 4'd5,
		CMD_IN_DEG   = 4'd6,
		CMD_OUT_DEG  = 4'd7,
		CMD_SET_W    = 4'd8,
		CMD_GET      = 4'd9
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LABEL    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_EMIT,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic read_step;
		logic eval;
		logic emit;
		logic emit_done;
		logic out_pop;
	} ctrl_t;

	// Status back to the controller.
	typedef struct packed {
		logic scan_end;
		logic want_emit;
		logic out_full;
		logic no_result;
	} stat_t;

endpackage

### hdl/gebt_datapath.sv
module gebt_datapath #(
	parameter int EdgeCapacity = gebt_pkg::EdgeCapacityDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gebt_pkg::ctrl_t                  ctrl,
	output gebt_pkg::stat_t                  stat,
	input  logic [gebt_pkg::InTdataW-1:0]    in_data,
	input  logic [gebt_pkg::LabelW-1:0]      label_q_in,
	output logic [gebt_pkg::ResW-1:0]        out_data
);
	import gebt_pkg::*;

	localparam int IdxW = $clog2(EdgeCapacity);
	localparam int CntW = $clog2(EdgeCapacity + 1);

	// Edge memory: one write and one read port.
	logic [3*DataW-1:0] mem [EdgeCapacity];

	logic [3:0]       cmd_q;
	logic [DataW-1:0] src_q, dst_q, qv_q, w_q;
	logic             wp_q;
	logic [CntW-1:0]  count_q, rd_q, wr_q, hits_q;
	logic [3*DataW-1:0] rdata_q;
	logic             found_q, add_q;
	logic [ResW-1:0]  res_q;
	logic             res_full_q;
	logic [ResW-1:0]  pend_q;
	logic             pend_valid_q;
	logic             res_load;
	logic             in_label_bad_q;

	logic [DataW-1:0] es, ed, ew;
	logic             hit, pair_hit, del_now;
	logic [DataW-1:0] nb;

	assign es = rdata_q[DataW-1:0];
	assign ed = rdata_q[2*DataW-1:DataW];
	assign ew = rdata_q[3*DataW-1:2*DataW];
	assign pair_hit = (es == src_q) && (ed == dst_q);

	// Hit and neighbor for the entry under evaluation.
	always_comb begin
		hit = 1'b0;
		nb = '0;
		del_now = 1'b0;
		case (cmd_q) inside
			CMD_DEL_EDGE: begin
				hit = pair_hit && !found_q;
				del_now = hit;
			end
			CMD_DEL_VTX: begin
				hit = (es == qv_q) || (ed == qv_q);
				del_now = hit;
			end
			CMD_LIST_IN, CMD_IN_DEG: begin
				hit = (ed == qv_q);
				nb = es;
			end
			CMD_LIST_OUT, CMD_OUT_DEG: begin
				hit = (es == qv_q);
				nb = ed;
			end
			CMD_LIST_ALL: begin
				hit = (es == qv_q) || (ed == qv_q);
				nb = (es == qv_q) ? ed : es;
			end
			CMD_SET_W, CMD_GET: hit = pair_hit && !found_q;
			default: hit = 1'b0;
		endcase
	end

	logic is_list;
	assign is_list = (cmd_q == CMD_LIST_IN) || (cmd_q == CMD_LIST_OUT)
		|| (cmd_q == CMD_LIST_ALL);

	assign stat.scan_end = (rd_q == count_q) || (cmd_q == CMD_ADD);
	assign stat.want_emit = is_list && hit;
	assign stat.out_full = res_full_q;
	assign stat.no_result = (cmd_q > CMD_GET);

	// The output register is loaded when a held listing result moves on,
	// and when the final result of a command is formed.
	assign res_load = (ctrl.emit && pend_valid_q) || ctrl.emit_done;

	function automatic logic [ResW-1:0] pack_res(
		input logic [1:0] st, input logic mv, input logic [DataW-1:0] s,
		input logic [DataW-1:0] d, input logic [DataW-1:0] w,
		input logic [DataW-1:0] n, input logic [DegW-1:0] dg, input logic lst);
		return {lst, dg, n, w, d, s, mv, st};
	endfunction

	logic [DegW-1:0] hits_deg;
	assign hits_deg = DegW'(hits_q);

	// Memory port: reads for the scan, writes for add, compaction and set.
	always_ff @(posedge clk) begin
		if (ctrl.read_step) begin
			rdata_q <= mem[rd_q[IdxW-1:0]];
		end
		if (ctrl.load && in_data[3:0] == CMD_ADD && in_data[140:133] == label_q_in
			&& count_q < CntW'(EdgeCapacity)) begin
			mem[count_q[IdxW-1:0]] <= {(in_data[132] ? in_data[131:100] : DataW'(1)),
				in_data[67:36], in_data[35:4]};
		end else if (ctrl.eval && !del_now && wr_q != rd_q - CntW'(1)) begin
			mem[wr_q[IdxW-1:0]] <= rdata_q;
		end else if (ctrl.eval && hit && cmd_q == CMD_SET_W && wp_q) begin
			mem[wr_q[IdxW-1:0]] <= {w_q, ed, es};
		end
	end

	// Scan control, counters and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			hits_q <= '0;
			found_q <= 1'b0;
			add_q <= 1'b0;
			res_full_q <= 1'b0;
			pend_valid_q <= 1'b0;
			cmd_q <= '0;
		end else begin
			if (ctrl.load) begin
				cmd_q <= in_data[3:0];
				rd_q <= '0;
				wr_q <= '0;
				hits_q <= '0;
				found_q <= 1'b0;
				add_q <= 1'b0;
				pend_valid_q <= 1'b0;
				if (in_data[3:0] == CMD_ADD && in_data[140:133] == label_q_in
					&& count_q < CntW'(EdgeCapacity)) begin
					count_q <= count_q + CntW'(1);
					add_q <= 1'b1;
				end
			end
			if (ctrl.read_step) rd_q <= rd_q + CntW'(1);
			if (ctrl.eval) begin
				if (hit) begin
					hits_q <= hits_q + CntW'(1);
					found_q <= 1'b1;
				end
				if (!del_now) wr_q <= wr_q + CntW'(1);
			end
			if (ctrl.emit) pend_valid_q <= 1'b1;
			if (res_load) res_full_q <= 1'b1;
			else if (ctrl.out_pop) res_full_q <= 1'b0;
			if (ctrl.emit_done) count_q <= count_q - (rd_q - wr_q);
		end
	end

	logic [DataW-1:0] hit_s_q, hit_d_q, hit_w_q;

	// Payload registers; a listing keeps its latest hit back until the next
	// hit or the end of the scan shows whether it is the final one.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			src_q <= in_data[35:4];
			dst_q <= in_data[67:36];
			qv_q <= in_data[99:68];
			w_q <= in_data[131:100];
			wp_q <= in_data[132];
		end
		if (ctrl.eval && hit && !found_q) begin
			hit_s_q <= es;
			hit_d_q <= ed;
			hit_w_q <= (cmd_q == CMD_SET_W && wp_q) ? w_q : ew;
		end
		if (ctrl.emit) begin
			pend_q <= pack_res(ST_OK, 1'b1, es, ed, ew, nb, '0, 1'b0);
			if (pend_valid_q) res_q <= pend_q;
		end else if (ctrl.emit_done) begin
			unique case (cmd_q) inside
				CMD_ADD:
					res_q <= pack_res(add_q ? ST_OK : (in_label_bad_q ? ST_LABEL : ST_FULL),
						1'b0, '0, '0, '0, '0, '0, 1'b1);
				CMD_DEL_VTX, CMD_IN_DEG, CMD_OUT_DEG:
					res_q <= pack_res(ST_OK, 1'b0, '0, '0, '0, '0, hits_deg, 1'b1);
				CMD_LIST_IN, CMD_LIST_OUT, CMD_LIST_ALL:
					res_q <= pend_valid_q ? {1'b1, pend_q[ResW-2:0]}
						: pack_res(ST_OK, 1'b0, '0, '0, '0, '0, '0, 1'b1);
				default:
					res_q <= found_q
						? pack_res(ST_OK, 1'b1, hit_s_q, hit_d_q, hit_w_q, '0, '0, 1'b1)
						: pack_res(ST_NOTFOUND, 1'b0, '0, '0, '0, '0, '0, 1'b1);
			endcase
		end
	end

	// Label check is captured at load for the add status.
	always_ff @(posedge clk) begin
		if (ctrl.load) in_label_bad_q <= in_data[140:133] != label_q_in;
	end

	assign out_data = res_q;

endmodule

### hdl/gebt_ctrl.sv
module gebt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            out_ready,
	input  gebt_pkg::stat_t stat,
	output gebt_pkg::ctrl_t ctrl,
	output logic            busy
);
	import gebt_pkg::*;

	state_t state_q, state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = S_READ;
			S_READ: if (stat.scan_end) state_d = S_DONE;
				else state_d = S_EVAL;
			S_EVAL: if (stat.want_emit) state_d = S_EMIT;
				else state_d = S_READ;
			S_EMIT: if (!stat.out_full || out_ready) state_d = S_READ;
			S_DONE: if (stat.no_result) state_d = S_IDLE;
				else if (!stat.out_full || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		ctrl = '0;
		busy = (state_q != S_IDLE);
		ctrl.out_pop = stat.out_full && out_ready;
		unique case (state_q)
			S_IDLE: ctrl.load = in_fire;
			S_READ: ctrl.read_step = !stat.scan_end;
			S_EVAL: ctrl.eval = 1'b1;
			S_EMIT: ctrl.emit = !stat.out_full || out_ready;
			S_DONE: ctrl.emit_done = !stat.no_result && (!stat.out_full || out_ready);
			default: ctrl.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

### hdl/graph_edge_buffer_table.sv
// Graph edge buffer table: an ordered store of up to EDGE_CAPACITY directed
// weighted edges, driven by one command transaction at a time.
// The s_axis channel carries a command; the m_axis channel returns one or
// more result transactions, the final one with tlast set. Listing commands
// return one result per matching edge in buffer order; each listed edge is
// held back one step so that the final one can carry tlast.
// The cfg channel writes the table label and must be used only while idle;
// the block itself does not enforce this. A command walks the stored edges
// one entry at a time (read, then evaluate and write back), plus an emit
// step per listed edge. The final result is loaded in the done state, and
// the next command is accepted once the controller is back in idle. An add
// skips the walk and goes straight to the done state. Unused command codes
// walk the table and return nothing. Deletes compact the store in the same
// pass.
// When the receiver stalls, the held result waits in the output register
// and the walk pauses until it is taken.
// Reset empties the table and clears the label to zero; no clearing pass
// runs, since only entries below the edge count are ever read.
module graph_edge_buffer_table #(
	parameter int EDGE_CAPACITY = gebt_pkg::EdgeCapacityDefault
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// cmd, src_vertex, dst_vertex, query_vertex, weight_value,
	// weight_present, add_label, zero fill
	input  logic [gebt_pkg::InTdataW-1:0]   s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status, match_valid, out_src, out_dst, out_weight, neighbor, degree,
	// zero fill
	output logic [gebt_pkg::OutTdataW-1:0]  m_axis_tdata,
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gebt_pkg::LabelW-1:0]     cfg_data
);
	import gebt_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	logic busy;
	logic [LabelW-1:0] label_q;
	logic [ResW-1:0] res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) label_q <= '0;
		else if (cfg_valid) label_q <= cfg_data;
	end

	assign s_axis_tready = !busy;
	assign m_axis_tvalid = stat.out_full;
	assign m_axis_tlast = res[ResW-1];
	assign m_axis_tdata = OutTdataW'(res[ResW-2:0]);

	gebt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid && s_axis_tready),
		.out_ready(m_axis_tready), .stat(stat), .ctrl(ctrl), .busy(busy)
	);

	gebt_datapath #(.EdgeCapacity(EDGE_CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.in_data(s_axis_tdata), .label_q_in(label_q), .out_data(res)
	);

endmodule

### hdl/gebt_checker.sv
`include "graph_edge_buffer_table_assert.svh"
module gebt_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tlast
);
	`GEBT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
	`GEBT_ASSERT_NEXT(a_no_accept_after, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "command accepted while busy")
	`GEBT_ASSERT_IMPL(a_idle_no_out, clk, arst_n, s_axis_tready, !m_axis_tvalid || m_axis_tlast, "non-final result while idle")
endmodule

bind graph_edge_buffer_table gebt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tlast(m_axis_tlast)
);
